// ===== rtl/fdt_pkg.sv =====
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared widths, character codes and step-unit operation codes for the
// float-to-decimal-text core.
// ----------------------------------------------------------------------------
`default_nettype none

package fdt_pkg;

  localparam int FLOAT_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int BIN_W      = 31;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int WORK_W     = BCD_W + BIN_W;
  localparam int PROD_W     = 31;
  localparam int SHAMT_W    = 8;
  localparam int DEC_W      = 7;
  localparam int CNT_W      = 5;
  localparam int ND_W       = 4;

  localparam logic [BIN_W-1:0]   SAT_INT   = 31'h7FFF_FFFF;
  localparam logic [7:0]         EXP_SAT   = 8'd158;
  localparam logic [7:0]         EXP_INT   = 8'd150;
  localparam logic [SHAMT_W-1:0] SUB_SHIFT = 8'd149;
  localparam logic [DEC_W-1:0]   FRAC_MAX  = 7'd99;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Operations of the shared step unit.
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_NORM   = 2'd1;
  localparam logic [1:0] OP_DABBLE = 2'd2;
  localparam logic [1:0] OP_SKIP   = 2'd3;

  typedef struct packed {
    logic               neg;
    logic               flag;
    logic [BIN_W-1:0]   ipart;
    logic [PROD_W-1:0]  prod;
    logic [SHAMT_W-1:0] shamt;
  } decode_t;

endpackage

`default_nettype wire

// ===== rtl/fdt_if.sv =====
// ----------------------------------------------------------------------------
// fdt_if
// Valid/ready channel interfaces for the float request and the text result.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdt_in_if;
  logic                        valid;
  logic                        ready;
  logic [fdt_pkg::FLOAT_W-1:0] float_bits;
  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface

interface fdt_out_if;
  logic                       valid;
  logic                       ready;
  logic [fdt_pkg::CHAR_W-1:0] char_code;
  logic                       last_char;
  logic                       out_of_range;
  modport source (output valid, output char_code, output last_char,
                  output out_of_range, input ready);
  modport sink   (input valid, input char_code, input last_char,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/fdt_decode.sv =====
// ----------------------------------------------------------------------------
// fdt_decode
// Splits a single-precision pattern into sign, saturation flag, integer part,
// the fractional numerator times 100 and its binary scale.
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_decode (
  input  wire logic [fdt_pkg::FLOAT_W-1:0] float_bits,
  output fdt_pkg::decode_t                 dec
);

  logic                                sign;
  logic [7:0]                          bexp;
  logic [22:0]                         mant;
  logic [23:0]                         m;
  logic [fdt_pkg::SHAMT_W-1:0]         s;
  logic [7:0]                          e_full;
  logic [23:0]                         lowmask;
  logic [23:0]                         fnum;
  logic [fdt_pkg::PROD_W-1:0]          fnum_w;
  logic                                nan;

  always_comb begin
    sign    = float_bits[31];
    bexp    = float_bits[30:23];
    mant    = float_bits[22:0];
    nan     = (bexp == 8'hFF) && (mant != 23'd0);
    m       = (bexp == 8'd0) ? {1'b0, mant} : {1'b1, mant};
    s       = (bexp == 8'd0) ? fdt_pkg::SUB_SHIFT : (fdt_pkg::EXP_INT - bexp);
    e_full  = bexp - fdt_pkg::EXP_INT;
    lowmask = ~(24'hFF_FFFF << s[4:0]);
    fnum    = (s >= 8'd24) ? m : (m & lowmask);
    fnum_w  = {7'd0, fnum};

    dec.neg   = sign && !nan && ((bexp != 8'd0) || (mant != 23'd0));
    dec.flag  = 1'b0;
    dec.ipart = '0;
    dec.prod  = '0;
    dec.shamt = s;

    if (bexp >= fdt_pkg::EXP_SAT) begin
      dec.flag  = 1'b1;
      dec.ipart = fdt_pkg::SAT_INT;
    end else if (bexp >= fdt_pkg::EXP_INT) begin
      // Whole number: the mantissa moves left by at most seven places.
      dec.ipart = {7'd0, m} << e_full[2:0];
    end else begin
      dec.ipart = (s >= 8'd32) ? '0 : ({7'd0, m} >> s[4:0]);
      // Fraction numerator times 100, exact in 31 bits.
      dec.prod  = (fnum_w << 6) + (fnum_w << 5) + (fnum_w << 2);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fdt_step_unit.sv =====
// ----------------------------------------------------------------------------
// fdt_step_unit
// Shared one-step unit: rounding shift with sticky bit, double-dabble step,
// and leading-digit shift on the work word.
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_step_unit (
  input  wire logic [1:0]                 op,
  input  wire logic [fdt_pkg::WORK_W-1:0] work_in,
  output logic      [fdt_pkg::WORK_W-1:0] work_out
);

  localparam int BW = fdt_pkg::BIN_W;
  localparam int CW = fdt_pkg::BCD_W;

  logic [CW-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < fdt_pkg::BCD_DIGITS; i++) begin
      if (work_in[BW + 4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = work_in[BW + 4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = work_in[BW + 4*i +: 4];
      end
    end

    case (op)
      fdt_pkg::OP_NORM: begin
        // Bit 32 is sticky, bit 31 the round bit, bits 30:0 the value.
        work_out         = '0;
        work_out[32]     = work_in[32] | work_in[31];
        work_out[31]     = work_in[0];
        work_out[30:0]   = {1'b0, work_in[30:1]};
      end
      fdt_pkg::OP_DABBLE: begin
        work_out = {bcd_adj[CW-2:0], work_in[BW-1:0], 1'b0};
      end
      fdt_pkg::OP_SKIP: begin
        work_out = {work_in[fdt_pkg::WORK_W-5:BW], 4'd0, work_in[BW-1:0]};
      end
      default: begin
        work_out = work_in;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/float_to_decimal_text_core.sv =====
// ----------------------------------------------------------------------------
// float_to_decimal_text_core
// Converts one single-precision value into ASCII text with two fraction
// digits, one character per result request.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Payload                                | Handshake
//   ---------+-----------+----------------------------------------+----------
//   in_ch    | in        | float_bits[31:0]                       | valid/ready
//   out_ch   | out       | char_code[7:0], last_char, out_of_range| valid/ready
//
// A value is accepted, then the scaled fraction is shifted down to 24 bits
// (up to seven shifts) and rounded, followed by 31 double-dabble steps.
// Leading zero digits are then dropped and the characters (4 to 14) are
// emitted. The single shared step unit performs one shift step per cycle
// unless a stalled sink holds the sequencer. Reset is synchronous and active
// low; it clears the sequencer and the output valid. The core takes no new
// request until the last character has been loaded into the output register;
// a stalled sink simply holds the sequencer in its current emit state.
`default_nettype none

module float_to_decimal_text_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fdt_in_if.sink     in_ch,
  fdt_out_if.source  out_ch
);

  localparam int BW = fdt_pkg::BIN_W;
  localparam int WW = fdt_pkg::WORK_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_BCD  = 4'd2;
  localparam logic [3:0] S_SKIP = 4'd3;
  localparam logic [3:0] S_SIGN = 4'd4;
  localparam logic [3:0] S_INT  = 4'd5;
  localparam logic [3:0] S_DOT  = 4'd6;
  localparam logic [3:0] S_TENS = 4'd7;
  localparam logic [3:0] S_ONES = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic [WW-1:0]               work_r, work_nxt;
  logic [WW-1:0]               work_step;
  logic [1:0]                  op;
  logic                        neg_r, neg_nxt;
  logic                        flag_r, flag_nxt;
  logic [BW-1:0]               ipart_r, ipart_nxt;
  logic [fdt_pkg::SHAMT_W-1:0] s_r, s_nxt;
  logic [2:0]                  d_r, d_nxt;
  logic [fdt_pkg::DEC_W-1:0]   dec_r, dec_nxt;
  logic [fdt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fdt_pkg::ND_W-1:0]    nd_r, nd_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [fdt_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                        last_r, last_nxt;
  logic                        oor_r, oor_nxt;

  fdt_pkg::decode_t            dcd;
  logic                        in_acc;
  logic                        out_free;

  // Rounding of the scaled fraction and the digit split.
  logic [24:0]                 q_rnd;
  logic [fdt_pkg::SHAMT_W-1:0] sh;
  logic [24:0]                 q_sh;
  logic [fdt_pkg::DEC_W-1:0]   dec_val;
  logic [14:0]                 tens_prod;
  logic [3:0]                  tens;
  logic [fdt_pkg::DEC_W-1:0]   ones_w;

  fdt_decode u_decode (
    .float_bits (in_ch.float_bits),
    .dec        (dcd)
  );

  fdt_step_unit u_step (
    .op       (op),
    .work_in  (work_r),
    .work_out (work_step)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign out_free            = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.char_code    = char_r;
  assign out_ch.last_char    = last_r;
  assign out_ch.out_of_range = oor_r;

  always_comb begin
    // Once the value has shrunk below 2^24, round to nearest even and scale
    // back by the remaining binary exponent.
    q_rnd   = {1'b0, work_r[23:0]} + {24'd0, work_r[31] & (work_r[32] | work_r[0])};
    sh      = s_r - {5'd0, d_r};
    q_sh    = (sh >= 8'd25) ? '0 : (q_rnd >> sh[4:0]);
    dec_val = (q_sh > {18'd0, fdt_pkg::FRAC_MAX}) ? fdt_pkg::FRAC_MAX : q_sh[6:0];

    // Tens digit by reciprocal multiply; exact for values below 100.
    tens_prod = {8'd0, dec_r} * 15'd205;
    tens      = tens_prod[14:11];
    ones_w    = dec_r - ({3'd0, tens} * 7'd10);
  end

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_step;
    op            = fdt_pkg::OP_HOLD;
    neg_nxt       = neg_r;
    flag_nxt      = flag_r;
    ipart_nxt     = ipart_r;
    s_nxt         = s_r;
    d_nxt         = d_r;
    dec_nxt       = dec_r;
    cnt_nxt       = cnt_r;
    nd_nxt        = nd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    char_nxt      = char_r;
    last_nxt      = last_r;
    oor_nxt       = oor_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          work_nxt  = {{(WW-fdt_pkg::PROD_W){1'b0}}, dcd.prod};
          neg_nxt   = dcd.neg;
          flag_nxt  = dcd.flag;
          ipart_nxt = dcd.ipart;
          s_nxt     = dcd.shamt;
          d_nxt     = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (work_r[30:24] != 7'd0) begin
          op    = fdt_pkg::OP_NORM;
          d_nxt = d_r + 3'd1;
        end else begin
          dec_nxt   = dec_val;
          work_nxt  = {{fdt_pkg::BCD_W{1'b0}}, ipart_r};
          cnt_nxt   = fdt_pkg::CNT_W'(BW);
          state_nxt = S_BCD;
        end
      end
      S_BCD: begin
        op      = fdt_pkg::OP_DABBLE;
        cnt_nxt = cnt_r - fdt_pkg::CNT_W'(1);
        if (cnt_r == fdt_pkg::CNT_W'(1)) begin
          nd_nxt    = fdt_pkg::ND_W'(fdt_pkg::BCD_DIGITS);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop leading zero digits, keeping at least one.
        if ((work_r[WW-1 -: 4] == 4'd0) && (nd_r > fdt_pkg::ND_W'(1))) begin
          op     = fdt_pkg::OP_SKIP;
          nd_nxt = nd_r - fdt_pkg::ND_W'(1);
        end else begin
          state_nxt = neg_r ? S_SIGN : S_INT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = fdt_pkg::CH_MINUS;
          last_nxt      = 1'b0;
          oor_nxt       = flag_r;
          state_nxt     = S_INT;
        end
      end
      S_INT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = fdt_pkg::CH_ZERO + {4'd0, work_r[WW-1 -: 4]};
          last_nxt      = 1'b0;
          oor_nxt       = flag_r;
          op            = fdt_pkg::OP_SKIP;
          nd_nxt        = nd_r - fdt_pkg::ND_W'(1);
          if (nd_r == fdt_pkg::ND_W'(1)) begin
            state_nxt = S_DOT;
          end
        end
      end
      S_DOT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = fdt_pkg::CH_DOT;
          last_nxt      = 1'b0;
          oor_nxt       = flag_r;
          state_nxt     = S_TENS;
        end
      end
      S_TENS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = fdt_pkg::CH_ZERO + {4'd0, tens};
          last_nxt      = 1'b0;
          oor_nxt       = flag_r;
          state_nxt     = S_ONES;
        end
      end
      S_ONES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = fdt_pkg::CH_ZERO + {4'd0, ones_w[3:0]};
          last_nxt      = 1'b1;
          oor_nxt       = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    neg_r   <= neg_nxt;
    flag_r  <= flag_nxt;
    ipart_r <= ipart_nxt;
    s_r     <= s_nxt;
    d_r     <= d_nxt;
    dec_r   <= dec_nxt;
    cnt_r   <= cnt_nxt;
    nd_r    <= nd_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    oor_r   <= oor_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/fdt_checker.sv =====
// ----------------------------------------------------------------------------
// fdt_checker
// Port-level checks of the float-to-decimal-text core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [fdt_pkg::CHAR_W-1:0] out_char_code,
  input wire logic                       out_last_char,
  input wire logic                       out_out_of_range
);

  // A new request closes the input until its text is out.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after a request was taken");

  // Mid-text characters mean the conversion is still running.
  a_no_ready_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |-> !in_ready)
    else $error("input ready while text incomplete");

  // The final character is always a fraction digit.
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |->
      (out_char_code >= fdt_pkg::CH_ZERO) && (out_char_code <= fdt_pkg::CH_NINE))
    else $error("final character is not a digit");

  // Saturated values end in a zero fraction.
  a_sat_fraction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char && out_out_of_range |-> out_char_code == fdt_pkg::CH_ZERO)
    else $error("saturated value with non-zero fraction");

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code))
    else $error("stalled character changed");

endmodule

bind float_to_decimal_text_core fdt_checker u_fdt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_char_code    (out_ch.char_code),
  .out_last_char    (out_ch.last_char),
  .out_out_of_range (out_ch.out_of_range)
);

`default_nettype wire
